>>> rtl/core/ssd_pkg.sv
// ----------------------------------------------------------------------------
// ssd_pkg
// Shared constants and lookup functions for the seven-segment decimal driver.
// ----------------------------------------------------------------------------
package ssd_pkg;

	// Default width of the signed number to show.
	localparam int VALUE_WIDTH_DEFAULT = 16;

	// Most digit frames produced for one number.
	localparam int MAX_RESULTS = 5;
	localparam int CNT_W       = $clog2(MAX_RESULTS);

	// Payload widths of one digit frame.
	localparam int SEG_W = 8;
	localparam int EN_W  = 8;

	// Reciprocal of ten: (x * RECIP_10) >> RECIP_SHIFT equals x / 10 for any
	// unsigned x of up to 32 bits.
	localparam int          RECIP_W     = 32;
	localparam logic [31:0] RECIP_10    = 32'hCCCC_CCCD;
	localparam int          RECIP_SHIFT = 35;

	// Negative numbers with a magnitude at or above this limit are not shown.
	localparam logic [31:0] NEG_LIMIT = 32'd1000;

	// Segment table index of the minus sign.
	localparam logic [3:0] MINUS_INDEX = 4'd10;

	// Active-low segment pattern for digits 0 to 9 and the minus sign.
	function automatic logic [SEG_W-1:0] seg_code(input logic [3:0] idx);
		logic [SEG_W-1:0] code;
		unique case (idx)
			4'd0:        code = 8'b0000_0011;
			4'd1:        code = 8'b1001_1111;
			4'd2:        code = 8'b0010_0101;
			4'd3:        code = 8'b0000_1101;
			4'd4:        code = 8'b1001_1001;
			4'd5:        code = 8'b0100_1001;
			4'd6:        code = 8'b0100_0001;
			4'd7:        code = 8'b0001_1111;
			4'd8:        code = 8'b0000_0001;
			4'd9:        code = 8'b0000_1001;
			MINUS_INDEX: code = 8'b1111_1101;
			default:     code = 8'b1111_1111;
		endcase
		return code;
	endfunction

	// One-hot digit select for the frame at a zero-based slot. Slot zero is
	// position one and drives bit four; slots past bit seven select nothing.
	function automatic logic [EN_W-1:0] enable_code(input logic [CNT_W-1:0] slot);
		logic [EN_W-1:0] en;
		case (slot)
			3'd0:    en = 8'h10;
			3'd1:    en = 8'h20;
			3'd2:    en = 8'h40;
			3'd3:    en = 8'h80;
			default: en = 8'h00;
		endcase
		return en;
	endfunction

endpackage

>>> rtl/core/ssd_in_if.sv
// ----------------------------------------------------------------------------
// ssd_in_if
// Valid/ready channel that carries one signed number per transfer.
// ----------------------------------------------------------------------------
interface ssd_in_if #(
	parameter int VALUE_WIDTH = ssd_pkg::VALUE_WIDTH_DEFAULT
);
	logic                          valid;
	logic                          ready;
	logic signed [VALUE_WIDTH-1:0] value;

	modport source (output valid, output value, input ready);
	modport sink   (input valid, input value, output ready);
endinterface

>>> rtl/core/ssd_out_if.sv
// ----------------------------------------------------------------------------
// ssd_out_if
// Valid/ready channel that carries one digit frame per transfer.
// ----------------------------------------------------------------------------
interface ssd_out_if;
	logic                        valid;
	logic                        ready;
	logic [ssd_pkg::SEG_W-1:0]   segment_code;
	logic [ssd_pkg::EN_W-1:0]    digit_enable;
	logic                        last;

	modport source (output valid, output segment_code, output digit_enable, output last,
		input ready);
	modport sink   (input valid, input segment_code, input digit_enable, input last,
		output ready);
endinterface

>>> rtl/core/ssd_div10.sv
// ----------------------------------------------------------------------------
// ssd_div10
// Shared divide-by-ten unit: one registered reciprocal multiply, then the
// quotient and the decimal remainder taken from the registered product.
// ----------------------------------------------------------------------------
module ssd_div10 #(
	parameter int VALUE_WIDTH = ssd_pkg::VALUE_WIDTH_DEFAULT
) (
	input  logic                   clk,
	input  logic                   load,
	input  logic [VALUE_WIDTH-1:0] dividend,
	output logic [VALUE_WIDTH-4:0] quotient,
	output logic [3:0]             remainder
);

	localparam int PROD_W = VALUE_WIDTH + ssd_pkg::RECIP_W;

	logic [PROD_W-1:0]      prod_s1;
	logic [VALUE_WIDTH-1:0] dividend_s1;
	logic [VALUE_WIDTH-1:0] times_ten;

	// Multiply by the reciprocal of ten and hold the product.
	always_ff @(posedge clk) begin
		if (load) begin
			prod_s1     <= PROD_W'(dividend) * PROD_W'(ssd_pkg::RECIP_10);
			dividend_s1 <= dividend;
		end
	end

	// Quotient is the upper part of the product; remainder is what is left.
	assign quotient  = prod_s1[PROD_W-1:ssd_pkg::RECIP_SHIFT];
	assign times_ten = {quotient, 3'b000} + VALUE_WIDTH'({quotient, 1'b0});
	assign remainder = 4'(dividend_s1 - times_ten);

endmodule

>>> rtl/core/seven_segment_decimal_driver.sv
// ----------------------------------------------------------------------------
// seven_segment_decimal_driver
// Turns a signed number into seven-segment digit frames, least significant
// digit first, with a trailing minus sign for small negative numbers.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Payload                               Handshake
//  number    sink       value (VALUE_WIDTH, signed)           valid / ready
//  frame     source     segment_code, digit_enable, last      valid / ready
//
// A number is taken only while the sequencer is idle. Each digit passes
// through the multiply state of the shared divide-by-ten unit, then the emit
// state that takes its quotient and remainder; a minus sign adds the sign
// state. Negative numbers of -1000 and below are dropped in the accept cycle.
// A stalled frame holds the sequencer in its emit or sign state; the last
// frame may wait while the next number is taken.
// Reset clears the sequencer and the frame valid flag.
//
module seven_segment_decimal_driver #(
	parameter int VALUE_WIDTH = ssd_pkg::VALUE_WIDTH_DEFAULT
) (
	input  logic      clk,
	input  logic      arst_n,
	ssd_in_if.sink    number,
	ssd_out_if.source frame
);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_MUL  = 4'b0010,
		ST_EMIT = 4'b0100,
		ST_SIGN = 4'b1000
	} state_t;

	state_t                      state_q;
	logic [VALUE_WIDTH-1:0]      mag_q;
	logic                        neg_q;
	logic [ssd_pkg::CNT_W-1:0]   cnt_q;

	logic                        frame_valid_q;
	logic [ssd_pkg::SEG_W-1:0]   seg_q;
	logic [ssd_pkg::EN_W-1:0]    en_q;
	logic                        last_q;

	logic                        in_xfer;
	logic                        in_neg;
	logic [VALUE_WIDTH-1:0]      in_mag;
	logic                        in_drop;
	logic                        slot_free;
	logic [VALUE_WIDTH-4:0]      quotient;
	logic [3:0]                  remainder;
	logic                        quot_zero;
	logic                        last_digit;

	// Input side: magnitude and the out-of-range check for negative numbers.
	assign number.ready = (state_q == ST_IDLE);
	assign in_xfer      = number.valid && number.ready;
	assign in_neg       = number.value[VALUE_WIDTH-1];
	assign in_mag       = in_neg ? VALUE_WIDTH'(-number.value) : VALUE_WIDTH'(number.value);
	assign in_drop      = in_neg && (32'(in_mag) >= ssd_pkg::NEG_LIMIT);

	// Shared divide-by-ten unit.
	ssd_div10 #(
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_div10 (
		.clk       (clk),
		.load      (state_q == ST_MUL),
		.dividend  (mag_q),
		.quotient  (quotient),
		.remainder (remainder)
	);

	// The output register can take a frame when empty or when its frame leaves.
	assign slot_free  = !frame_valid_q || frame.ready;
	assign quot_zero  = (quotient == '0);
	assign last_digit = (cnt_q == ssd_pkg::CNT_W'(ssd_pkg::MAX_RESULTS - 1))
		|| (quot_zero && !neg_q);

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			neg_q   <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_xfer && !in_drop) begin
						state_q <= ST_MUL;
						cnt_q   <= '0;
						neg_q   <= in_neg;
					end
				end
				ST_MUL: begin
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (slot_free) begin
						cnt_q <= cnt_q + 1'b1;
						if (last_digit) begin
							state_q <= ST_IDLE;
						end else if (quot_zero) begin
							state_q <= ST_SIGN;
						end else begin
							state_q <= ST_MUL;
						end
					end
				end
				ST_SIGN: begin
					if (slot_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Running magnitude: loaded on accept, replaced by the quotient per digit.
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			mag_q <= in_mag;
		end else if (state_q == ST_EMIT && slot_free) begin
			mag_q <= VALUE_WIDTH'(quotient);
		end
	end

	// Output register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_valid_q <= 1'b0;
		end else if ((state_q == ST_EMIT || state_q == ST_SIGN) && slot_free) begin
			frame_valid_q <= 1'b1;
		end else if (frame.ready) begin
			frame_valid_q <= 1'b0;
		end
	end

	// Output register payload: a digit or the minus sign.
	always_ff @(posedge clk) begin
		if (state_q == ST_EMIT && slot_free) begin
			seg_q  <= ssd_pkg::seg_code(remainder);
			en_q   <= ssd_pkg::enable_code(cnt_q);
			last_q <= last_digit;
		end else if (state_q == ST_SIGN && slot_free) begin
			seg_q  <= ssd_pkg::seg_code(ssd_pkg::MINUS_INDEX);
			en_q   <= ssd_pkg::enable_code(cnt_q);
			last_q <= 1'b1;
		end
	end

	assign frame.valid        = frame_valid_q;
	assign frame.segment_code = seg_q;
	assign frame.digit_enable = en_q;
	assign frame.last         = last_q;

	// A frame past the last enable bit is always the final one.
	assert property (@(posedge clk) disable iff (!arst_n)
		frame.valid && frame.digit_enable == '0 |-> frame.last)
		else $error("frame beyond the last digit select is not marked last");

	// The minus sign always closes a number.
	assert property (@(posedge clk) disable iff (!arst_n)
		frame.valid && frame.segment_code == ssd_pkg::seg_code(ssd_pkg::MINUS_INDEX)
		|-> frame.last)
		else $error("minus sign frame is not marked last");

	// The digit count never reaches the frame limit while a number is in work.
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q != ST_IDLE |-> cnt_q < ssd_pkg::CNT_W'(ssd_pkg::MAX_RESULTS))
		else $error("digit count overran the frame limit");

	// A multiply is always followed by an emit cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_MUL |=> state_q == ST_EMIT)
		else $error("divide unit result not consumed after multiply");

endmodule

>>> tb/seven_segment_decimal_driver_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// seven_segment_decimal_driver_tb
// Self-checking testbench for the seven-segment decimal driver. Numbers are
// pushed through the number channel from a queue. Each accepted number is
// turned into its expected digit frames by a local predictor. The frames that
// come out are checked in order, field by field. Both channels idle at random
// rates that change from phase to phase.
// ----------------------------------------------------------------------------
module seven_segment_decimal_driver_tb;

	localparam int VW           = ssd_pkg::VALUE_WIDTH_DEFAULT;
	localparam int FRAME_MAX    = ssd_pkg::MAX_RESULTS;
	localparam int DRAIN_CYCLES = 20;
	localparam int STALL_LIMIT  = 1000;
	localparam int REPORT_MAX   = 10;
	localparam int RANDOM_COUNT = 24;

	// Active-low patterns for digits 0 to 9, with the minus sign last.
	localparam logic [7:0] DIGIT_PATTERN [0:10] = '{
		8'h03, 8'h9F, 8'h25, 8'h0D, 8'h99,
		8'h49, 8'h41, 8'h1F, 8'h01, 8'h09,
		8'hFD
	};

	typedef struct packed {
		logic [7:0] segment_code;
		logic [7:0] digit_enable;
		logic       last;
	} frame_t;

	logic clk;
	logic arst_n;

	ssd_in_if #(.VALUE_WIDTH(VW)) number_if ();
	ssd_out_if frame_if ();

	logic signed [VW-1:0] pending_values [$];
	frame_t               expected_frames [$];
	int                   mismatch_count = 0;
	int                   send_idle_pct;
	int                   recv_stall_pct;
	int                   quiet_cycles;

	seven_segment_decimal_driver #(.VALUE_WIDTH(VW)) u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.number (number_if.sink),
		.frame  (frame_if.source)
	);

	// Clock generation.
	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Records one failure; only the first few are printed in full.
	function automatic void note_failure(input string msg);
		if (mismatch_count < REPORT_MAX) begin
			$display("[%0t] mismatch: %s", $time, msg);
		end
		mismatch_count++;
	endfunction

	// One-hot digit select for a position counted from one.
	function automatic logic [7:0] position_enable(input int pos);
		if (pos + 3 > 7) begin
			return 8'h00;
		end
		return 8'h01 << (pos + 3);
	endfunction

	// Queues the digit frames that one accepted number should produce.
	function automatic void predict_frames(input logic signed [VW-1:0] v);
		int     mag;
		int     pos;
		bit     neg;
		frame_t f;
		neg = (v < 0);
		mag = neg ? -int'(v) : int'(v);
		pos = 0;
		// Zero shows a single digit.
		if (mag == 0) begin
			f = '{DIGIT_PATTERN[0], position_enable(1), 1'b1};
			expected_frames.push_back(f);
			return;
		end
		// Negative numbers that need a fourth digit are not shown.
		if (neg && mag >= 1000) begin
			return;
		end
		while (mag > 0 && pos < FRAME_MAX) begin
			pos++;
			f.segment_code = DIGIT_PATTERN[mag % 10];
			f.digit_enable = position_enable(pos);
			mag = mag / 10;
			f.last = (mag == 0 && !neg) || pos == FRAME_MAX;
			expected_frames.push_back(f);
		end
		// Small negative numbers end with a minus sign.
		if (neg && pos < FRAME_MAX) begin
			pos++;
			f = '{DIGIT_PATTERN[ssd_pkg::MINUS_INDEX], position_enable(pos), 1'b1};
			expected_frames.push_back(f);
		end
	endfunction

	// Random number, weighted toward values that are actually displayed.
	function automatic logic signed [VW-1:0] random_value();
		int pick;
		pick = $urandom_range(99);
		if (pick < 35) begin
			return VW'($urandom_range(32767));
		end else if (pick < 65) begin
			return VW'(-$urandom_range(999, 1));
		end else if (pick < 80) begin
			return VW'($urandom_range(99));
		end
		return VW'($urandom);
	endfunction

	// Number driver: predicts on each transfer, then offers the next number.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			number_if.valid <= 1'b0;
			number_if.value <= '0;
		end else begin
			if (number_if.valid && number_if.ready) begin
				predict_frames(number_if.value);
			end
			if (!number_if.valid || number_if.ready) begin
				if (pending_values.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					number_if.valid <= 1'b1;
					number_if.value <= pending_values.pop_front();
				end else begin
					number_if.valid <= 1'b0;
				end
			end
		end
	end

	// Frame monitor: checks each transfer against the oldest expected frame.
	always @(posedge clk or negedge arst_n) begin
		frame_t got;
		frame_t want;
		if (!arst_n) begin
			frame_if.ready <= 1'b0;
		end else begin
			if (frame_if.valid && frame_if.ready) begin
				got = '{frame_if.segment_code, frame_if.digit_enable, frame_if.last};
				if (expected_frames.size() == 0) begin
					note_failure($sformatf("unexpected frame seg=%h en=%h last=%b",
						got.segment_code, got.digit_enable, got.last));
				end else begin
					want = expected_frames.pop_front();
					if (got.segment_code !== want.segment_code
						|| got.digit_enable !== want.digit_enable
						|| got.last !== want.last) begin
						note_failure($sformatf(
							"expected seg=%h en=%h last=%b, got seg=%h en=%h last=%b",
							want.segment_code, want.digit_enable, want.last,
							got.segment_code, got.digit_enable, got.last));
					end
				end
			end
			frame_if.ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Watchdog: ends the run when neither channel moves for too long.
	always @(posedge clk) begin
		if (!arst_n || (number_if.valid && number_if.ready)
			|| (frame_if.valid && frame_if.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("FAIL");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Stimulus: directed numbers, then random phases with different idling.
	initial begin
		int directed [] = '{
			0, 1, -1, 9, -9, 10, -10, 99, -99, 100, -100, 999, -999,
			-1000, -1001, 1000, 9999, 10000, 32767, -32768, 12345, -500,
			16'sh5555, 16'sh2AAA
		};
		send_idle_pct   = 0;
		recv_stall_pct  = 0;
		arst_n          = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin
					send_idle_pct  = 0;
					recv_stall_pct = 0;
					foreach (directed[i]) pending_values.push_back(VW'(directed[i]));
				end
				1: begin
					send_idle_pct  = 69;
					recv_stall_pct = 0;
				end
				2: begin
					send_idle_pct  = 0;
					recv_stall_pct = 69;
				end
				default: begin
					send_idle_pct  = 9;
					recv_stall_pct = 9;
				end
			endcase
			repeat (RANDOM_COUNT) pending_values.push_back(random_value());
			// Hold the next phase back until every expected frame has come.
			while (pending_values.size() != 0 || number_if.valid
				|| expected_frames.size() != 0) begin
				@(posedge clk);
			end
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (expected_frames.size() != 0) begin
			$display("[%0t] mismatch: %0d frames never arrived", $time,
				expected_frames.size());
		end
		if (mismatch_count == 0 && expected_frames.size() == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
